// ===== hdl/ffpa_pkg.sv =====
package ffpa_pkg;

    localparam int PAGE_INDEX_BITS = 16;
    localparam int LEN_BITS        = PAGE_INDEX_BITS + 1;
    localparam int MAX_EXTENTS_DEF = 64;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_ALLOC = 2'd2,
        FUNC_FREE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    typedef struct packed {
        func_t                       func;
        logic [PAGE_INDEX_BITS-1:0]  page_base;
        logic [LEN_BITS-1:0]         page_count;
    } req_t;

    typedef struct packed {
        status_t                     status;
        logic [PAGE_INDEX_BITS-1:0]  alloc_start;
        logic [LEN_BITS-1:0]         free_total;
    } rsp_t;

    typedef struct packed {
        logic [PAGE_INDEX_BITS-1:0]  start;
        logic [LEN_BITS-1:0]         length;
    } entry_t;

    function automatic logic [LEN_BITS-1:0] sat_add(
        input logic [LEN_BITS-1:0] a,
        input logic [LEN_BITS-1:0] b
    );
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
    endfunction

    function automatic logic [LEN_BITS:0] ext_end(
        input logic [PAGE_INDEX_BITS-1:0] s,
        input logic [LEN_BITS-1:0]        l
    );
        return (LEN_BITS+1)'(s) + (LEN_BITS+1)'(l);
    endfunction

endpackage

// ===== hdl/first_fit_page_allocator_core.sv =====
// First-fit page allocator with coalescing.
// Request channel req_valid/req_ready/req carries one request beat:
// func (clear, add region, allocate, free extent), page_base, page_count.
// Response channel rsp_valid/rsp_ready/rsp returns exactly one beat per
// request: status, alloc_start (zero unless an allocate succeeds) and the
// free page total after the request.
// Free extents live in one table memory with a registered read; every table
// step is a read state followed by an evaluate/write state.
// Clear, zero count and add finish without a table pass. Allocate scans
// entries up to the fit, then moves entries down when an extent is used
// up. Free runs a merge pass over all entries, a position search and a
// move of entries up to open the slot. One request is worked at a time.
// Reset empties the table and zeroes the free total at once; no sweep.
// When the receiver stalls, the finished beat holds in the response
// register; a new request is still taken and worked, and waits to finish
// until that register frees up.
module first_fit_page_allocator_core
    import ffpa_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ALC_RD, S_ALC_EV, S_SHD_RD, S_SHD_EV,
        S_FRE_RD, S_FRE_EV, S_POS_RD, S_POS_EV, S_SHU_RD, S_SHU_EV, S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    req_t                       req_reg, req_next;
    logic [CW-1:0]              used_reg, used_next;
    logic [LEN_BITS-1:0]        free_reg, free_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              wr_reg, wr_next;
    logic [PAGE_INDEX_BITS-1:0] b_reg, b_next;
    logic [LEN_BITS-1:0]        len_reg, len_next;
    status_t                    st_reg, st_next;
    logic [PAGE_INDEX_BITS-1:0] start_reg, start_next;
    logic                       ov_reg, ov_next;
    rsp_t                       rsp_reg, rsp_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [IW-1:0] mem_raddr;
    entry_t        mem_rdata;
    logic [CW-1:0] idx_inc;

    ffpa_mem #(
        .DEPTH (MAX_EXTENTS),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp       = rsp_reg;
    assign idx_inc   = idx_reg + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        used_next  = used_reg;
        free_next  = free_reg;
        idx_next   = idx_reg;
        wr_next    = wr_reg;
        b_next     = b_reg;
        len_next   = len_reg;
        st_next    = st_reg;
        start_next = start_reg;
        ov_next    = ov_reg;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[IW-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = idx_reg[IW-1:0];

        if (ov_reg && rsp_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                st_next    = ST_OK;
                start_next = '0;
                idx_next   = '0;
                wr_next    = '0;
                b_next     = req_reg.page_base;
                len_next   = req_reg.page_count;
                state_next = S_DONE;
                if (req_reg.func == FUNC_CLEAR)
                begin
                    used_next = '0;
                    free_next = '0;
                end
                else if (req_reg.page_count == '0)
                begin
                    st_next = ST_ZERO;
                end
                else
                begin
                    case (req_reg.func)
                        FUNC_ADD:
                        begin
                            if (used_reg >= MAX_CNT)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = used_reg[IW-1:0];
                                mem_wdata = '{start: req_reg.page_base,
                                              length: req_reg.page_count};
                                used_next = used_reg + CW'(1);
                                free_next = sat_add(free_reg, req_reg.page_count);
                            end
                        end
                        FUNC_ALLOC:
                        begin
                            if (req_reg.page_count > free_reg)
                            begin
                                st_next = ST_NOFIT;
                            end
                            else
                            begin
                                state_next = S_ALC_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FRE_RD;
                        end
                    endcase
                end
            end
            S_ALC_RD:
            begin
                if (idx_reg == used_reg)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ALC_EV;
                end
            end
            S_ALC_EV:
            begin
                if (mem_rdata.length >= req_reg.page_count)
                begin
                    start_next = mem_rdata.start;
                    free_next  = free_reg - req_reg.page_count;
                    if (mem_rdata.length > req_reg.page_count)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = '{start: mem_rdata.start
                                          + req_reg.page_count[PAGE_INDEX_BITS-1:0],
                                       length: mem_rdata.length - req_reg.page_count};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHD_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_ALC_RD;
                end
            end
            S_SHD_RD:
            begin
                mem_raddr = idx_inc[IW-1:0];
                if (idx_inc >= used_reg)
                begin
                    used_next  = used_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHD_EV;
                end
            end
            S_SHD_EV:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = S_SHD_RD;
            end
            S_FRE_RD:
            begin
                if (idx_reg == used_reg)
                begin
                    used_next = wr_reg;
                    idx_next  = '0;
                    if (wr_reg >= MAX_CNT)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_POS_RD;
                    end
                end
                else
                begin
                    state_next = S_FRE_EV;
                end
            end
            S_FRE_EV:
            begin
                if (ext_end(mem_rdata.start, mem_rdata.length) == (LEN_BITS+1)'(b_reg))
                begin
                    b_next   = mem_rdata.start;
                    len_next = sat_add(len_reg, mem_rdata.length);
                end
                else if (ext_end(b_reg, len_reg) == (LEN_BITS+1)'(mem_rdata.start))
                begin
                    len_next = sat_add(len_reg, mem_rdata.length);
                end
                else
                begin
                    mem_we    = (wr_reg != idx_reg);
                    mem_waddr = wr_reg[IW-1:0];
                    wr_next   = wr_reg + CW'(1);
                end
                idx_next   = idx_inc;
                state_next = S_FRE_RD;
            end
            S_POS_RD:
            begin
                if (idx_reg == used_reg)
                begin
                    wr_next    = used_reg;
                    state_next = S_SHU_RD;
                end
                else
                begin
                    state_next = S_POS_EV;
                end
            end
            S_POS_EV:
            begin
                if (ext_end(b_reg, len_reg) <= (LEN_BITS+1)'(mem_rdata.start))
                begin
                    wr_next    = used_reg;
                    state_next = S_SHU_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_POS_RD;
                end
            end
            S_SHU_RD:
            begin
                mem_raddr = IW'(wr_reg - CW'(1));
                if (wr_reg == idx_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{start: b_reg, length: len_reg};
                    used_next  = used_reg + CW'(1);
                    free_next  = sat_add(free_reg, req_reg.page_count);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHU_EV;
                end
            end
            S_SHU_EV:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wr_reg[IW-1:0];
                wr_next    = wr_reg - CW'(1);
                state_next = S_SHU_RD;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp_ready)
                begin
                    ov_next    = 1'b1;
                    rsp_next   = '{status: st_reg, alloc_start: start_reg,
                                   free_total: free_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            free_reg  <= '0;
            ov_reg    <= 1'b0;
            req_reg   <= '0;
            idx_reg   <= '0;
            wr_reg    <= '0;
            b_reg     <= '0;
            len_reg   <= '0;
            st_reg    <= ST_OK;
            start_reg <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            ov_reg    <= ov_next;
            req_reg   <= req_next;
            idx_reg   <= idx_next;
            wr_reg    <= wr_next;
            b_reg     <= b_next;
            len_reg   <= len_next;
            st_reg    <= st_next;
            start_reg <= start_next;
            rsp_reg   <= rsp_next;
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= MAX_CNT)
        else $error("extent count beyond table depth");

    a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_waddr) <= used_reg))
        else $error("table write beyond tail");

    a_start_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && rsp_reg.status != ST_OK) |-> (rsp_reg.alloc_start == '0))
        else $error("start reported on failed request");

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_DONE))
        else $error("response beat without finished request");

endmodule

// ===== hdl/ffpa_mem.sv =====
module ffpa_mem
    import ffpa_pkg::*;
#(
    parameter int DEPTH = MAX_EXTENTS_DEF,
    parameter int IW    = $clog2(DEPTH)
)(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [IW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== test/first_fit_page_allocator_core_test.sv =====
module first_fit_page_allocator_core_test;
    import ffpa_pkg::*;

    localparam int NUM_SLOTS   = MAX_EXTENTS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 300;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;

    class extent_scoreboard;
        logic [PAGE_INDEX_BITS-1:0] ext_start [NUM_SLOTS];
        logic [LEN_BITS-1:0]        ext_len   [NUM_SLOTS];
        int                         used;
        logic [LEN_BITS-1:0]        free_pg;
        rsp_t                       pending [$];
        logic [PAGE_INDEX_BITS-1:0] granted_base [$];
        logic [LEN_BITS-1:0]        granted_len  [$];
        int                         errors;

        function new();
            used = 0;
            free_pg = '0;
            errors = 0;
        endfunction

        function logic [LEN_BITS-1:0] clamp_sum(int a, int b);
            int s;
            s = a + b;
            return (s > (1 << LEN_BITS) - 1) ? {LEN_BITS{1'b1}} : LEN_BITS'(s);
        endfunction

        function void remove_slot(int idx);
            for (int k = idx; k + 1 < used; k++) begin
                ext_start[k] = ext_start[k+1];
                ext_len[k]   = ext_len[k+1];
            end
            used--;
        endfunction

        function status_t take_pages(int n, output logic [PAGE_INDEX_BITS-1:0] first);
            first = '0;
            if (n > int'(free_pg))
                return ST_NOFIT;
            for (int i = 0; i < used; i++) begin
                if (int'(ext_len[i]) >= n) begin
                    first = ext_start[i];
                    if (int'(ext_len[i]) > n) begin
                        ext_start[i] = PAGE_INDEX_BITS'(int'(ext_start[i]) + n);
                        ext_len[i]   = LEN_BITS'(int'(ext_len[i]) - n);
                    end
                    else
                        remove_slot(i);
                    free_pg = LEN_BITS'(int'(free_pg) - n);
                    return ST_OK;
                end
            end
            return ST_NOFIT;
        endfunction

        function status_t return_pages(int b, int n);
            int len;
            int i;
            int pos;
            len = n;
            i = 0;
            while (i < used) begin
                if (int'(ext_start[i]) + int'(ext_len[i]) == b) begin
                    b = ext_start[i];
                    len = clamp_sum(len, ext_len[i]);
                    remove_slot(i);
                end
                else if (b + len == int'(ext_start[i])) begin
                    len = clamp_sum(len, ext_len[i]);
                    remove_slot(i);
                end
                else
                    i++;
            end
            if (used >= NUM_SLOTS)
                return ST_FULL;
            pos = used;
            for (int j = 0; j < used; j++) begin
                if (b + len <= int'(ext_start[j])) begin
                    pos = j;
                    break;
                end
            end
            for (int k = used; k > pos; k--) begin
                ext_start[k] = ext_start[k-1];
                ext_len[k]   = ext_len[k-1];
            end
            ext_start[pos] = PAGE_INDEX_BITS'(b);
            ext_len[pos]   = LEN_BITS'(len);
            used++;
            free_pg = clamp_sum(free_pg, n);
            return ST_OK;
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            logic [PAGE_INDEX_BITS-1:0] first;
            e = '0;
            e.status = ST_OK;
            if (r.func == FUNC_CLEAR) begin
                used = 0;
                free_pg = '0;
                granted_base.delete();
                granted_len.delete();
            end
            else if (r.page_count == 0)
                e.status = ST_ZERO;
            else if (r.func == FUNC_ADD) begin
                if (used >= NUM_SLOTS)
                    e.status = ST_FULL;
                else begin
                    ext_start[used] = r.page_base;
                    ext_len[used]   = r.page_count;
                    used++;
                    free_pg = clamp_sum(free_pg, r.page_count);
                end
            end
            else if (r.func == FUNC_ALLOC) begin
                e.status = take_pages(r.page_count, first);
                if (e.status == ST_OK) begin
                    e.alloc_start = first;
                    granted_base.push_back(first);
                    granted_len.push_back(r.page_count);
                end
            end
            else
                e.status = return_pages(r.page_base, r.page_count);
            e.free_total = free_pg;
            pending.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (pending.size() == 0) begin
                $error("unexpected response beat: status %0d start %0d total %0d",
                       got.status, got.alloc_start, got.free_total);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.alloc_start !== e.alloc_start) begin
                $error("alloc_start: expected %0d, got %0d", e.alloc_start, got.alloc_start);
                errors++;
            end
            if (got.free_total !== e.free_total) begin
                $error("free_total: expected %0d, got %0d", e.free_total, got.free_total);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    extent_scoreboard sb;
    bit calm;
    bit hold_request;
    int cycles;

    first_fit_page_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("first_fit_page_allocator_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    function automatic req_t make_req(func_t f, int b, int n);
        req_t r;
        r.func = f;
        r.page_base = PAGE_INDEX_BITS'(b);
        r.page_count = LEN_BITS'(n);
        return r;
    endfunction

    task automatic send(req_t r);
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_count();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return $urandom_range(0, (1 << LEN_BITS) - 1);
        if (sel == 1)
            return 0;
        if (sel == 2)
            return 1 << PAGE_INDEX_BITS;
        return $urandom_range(1, 64);
    endfunction

    function automatic req_t pick_req();
        int sel;
        int idx;
        int part;
        logic [PAGE_INDEX_BITS-1:0] b;
        logic [LEN_BITS-1:0] n;
        sel = $urandom_range(0, 99);
        if (sel == 0)
            return make_req(FUNC_CLEAR, $urandom, $urandom);
        if (sel < 14)
            return make_req(FUNC_ADD, $urandom_range(0, 65535), pick_count() * 4);
        if (sel < 55)
            return make_req(FUNC_ALLOC, 0, pick_count());
        if (sb.granted_base.size() != 0 && sel < 92)
        begin
            idx = $urandom_range(0, sb.granted_base.size() - 1);
            b = sb.granted_base[idx];
            n = sb.granted_len[idx];
            sb.granted_base.delete(idx);
            sb.granted_len.delete(idx);
            if (n > 1 && $urandom_range(0, 2) == 0)
            begin
                part = $urandom_range(1, n - 1);
                sb.granted_base.push_back(PAGE_INDEX_BITS'(int'(b) + part));
                sb.granted_len.push_back(LEN_BITS'(int'(n) - part));
                n = part;
            end
            return make_req(FUNC_FREE, b, n);
        end
        return make_req(FUNC_FREE, $urandom_range(0, 65535), pick_count());
    endfunction

    initial
    begin
        clk = 1'b0;
        sb = new();
        calm = 1'b0;
        hold_request = 1'b0;
        cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_req(FUNC_CLEAR, 16'hFFFF, 17'h1FFFF));
        send(make_req(FUNC_ADD, 5, 0));
        send(make_req(FUNC_ALLOC, 0, 1));
        send(make_req(FUNC_ADD, 16'hFFFF, 2));
        send(make_req(FUNC_ALLOC, 0, 1));
        send(make_req(FUNC_ALLOC, 0, 2));
        send(make_req(FUNC_ADD, 100, 17'h1FFFF));
        send(make_req(FUNC_ADD, 40000, 17'h10000));
        send(make_req(FUNC_FREE, 0, 0));
        send(make_req(FUNC_ALLOC, 0, 0));
        send(make_req(FUNC_ALLOC, 0, 17'h1FFFF));
        send(make_req(FUNC_FREE, 16'hFFFF, 17'h1FFFF));
        send(make_req(FUNC_CLEAR, 0, 0));
        for (int i = 0; i < NUM_SLOTS; i++)
            send(make_req(FUNC_ADD, i * 4, 2));
        send(make_req(FUNC_ADD, 1000, 1));
        send(make_req(FUNC_FREE, 1000, 1));
        send(make_req(FUNC_FREE, 2, 2));
        send(make_req(FUNC_ALLOC, 0, 6));
        send(make_req(FUNC_FREE, 9, 3));
        send(make_req(FUNC_FREE, 500, 4));
        send(make_req(FUNC_ALLOC, 0, 3));

        drain();
        send(make_req(FUNC_CLEAR, 0, 0));
        hold_request = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain();
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send(pick_req());
        end
        req_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("first_fit_page_allocator_core regression: pass");
        else
            $display("first_fit_page_allocator_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ffpa_pkg.sv
hdl/ffpa_mem.sv
hdl/first_fit_page_allocator_core.sv
test/first_fit_page_allocator_core_test.sv
